/* hw/rtl/keysym_to_utf8_encoder_assert.svh */
// Assertion macros for the keysym to UTF-8 encoder.
// The including module provides clk_i and rst_ni.
`ifndef KEYSYM_TO_UTF8_ENCODER_ASSERT_SVH
`define KEYSYM_TO_UTF8_ENCODER_ASSERT_SVH

// Checked only outside reset.
`define KTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset too.
`define KTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/kte_pkg.sv */
`default_nettype none

package kte_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  localparam logic [31:0] KsUnicodeLo = 32'h0100_0100;
  localparam logic [31:0] KsUnicodeHi = 32'h0110_ffff;
  localparam logic [31:0] KsKpDigitLo = 32'h0000_ffb0;
  localparam logic [31:0] KsKpDigitHi = 32'h0000_ffb9;

  localparam logic [31:0] KsBackSpace   = 32'h0000_ff08;
  localparam logic [31:0] KsTab         = 32'h0000_ff09;
  localparam logic [31:0] KsKpTab       = 32'h0000_ff89;
  localparam logic [31:0] KsReturn      = 32'h0000_ff0d;
  localparam logic [31:0] KsKpEnter     = 32'h0000_ff8d;
  localparam logic [31:0] KsEscape      = 32'h0000_ff1b;
  localparam logic [31:0] KsDelete      = 32'h0000_ffff;
  localparam logic [31:0] KsKpDelete    = 32'h0000_ff9f;
  localparam logic [31:0] KsKpSpace     = 32'h0000_ff80;
  localparam logic [31:0] KsKpMultiply  = 32'h0000_ffaa;
  localparam logic [31:0] KsKpAdd       = 32'h0000_ffab;
  localparam logic [31:0] KsKpSeparator = 32'h0000_ffac;
  localparam logic [31:0] KsKpSubtract  = 32'h0000_ffad;
  localparam logic [31:0] KsKpDecimal   = 32'h0000_ffae;
  localparam logic [31:0] KsKpDivide    = 32'h0000_ffaf;

  localparam logic [CpW-1:0] CpSurrLo = 21'h00_d800;
  localparam logic [CpW-1:0] CpSurrHi = 21'h00_dfff;
  localparam logic [CpW-1:0] CpMax    = 21'h10_ffff;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  typedef struct packed {
    logic [3:0][7:0]  bytes;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  fit;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/kte_map.sv */
`default_nettype none

module kte_map (
  input  wire logic [31:0]              keysym_i,
  output logic      [kte_pkg::CpW-1:0]  cp_o
);

  always_comb begin
    cp_o = '0;
    if ((keysym_i >= 32'h20 && keysym_i <= 32'h7e) ||
        (keysym_i >= 32'ha0 && keysym_i <= 32'hff)) begin
      cp_o = {13'd0, keysym_i[7:0]};
    end else if (keysym_i >= kte_pkg::KsUnicodeLo && keysym_i <= kte_pkg::KsUnicodeHi) begin
      cp_o = keysym_i[kte_pkg::CpW-1:0];
    end else if (keysym_i >= kte_pkg::KsKpDigitLo && keysym_i <= kte_pkg::KsKpDigitHi) begin
      cp_o = {13'd0, 4'h3, keysym_i[3:0]};
    end else begin
      unique case (keysym_i)
        kte_pkg::KsBackSpace:                 cp_o = 21'h08;
        kte_pkg::KsTab, kte_pkg::KsKpTab:     cp_o = 21'h09;
        kte_pkg::KsReturn, kte_pkg::KsKpEnter: cp_o = 21'h0d;
        kte_pkg::KsEscape:                    cp_o = 21'h1b;
        kte_pkg::KsDelete, kte_pkg::KsKpDelete: cp_o = 21'h7f;
        kte_pkg::KsKpSpace:                   cp_o = 21'h20;
        kte_pkg::KsKpMultiply:                cp_o = 21'h2a;
        kte_pkg::KsKpAdd:                     cp_o = 21'h2b;
        kte_pkg::KsKpSeparator:               cp_o = 21'h2c;
        kte_pkg::KsKpSubtract:                cp_o = 21'h2d;
        kte_pkg::KsKpDecimal:                 cp_o = 21'h2e;
        kte_pkg::KsKpDivide:                  cp_o = 21'h2f;
        default:                              cp_o = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kte_encode.sv */
`default_nettype none

module kte_encode (
  input  wire logic [kte_pkg::CpW-1:0] cp_i,
  input  wire logic [7:0]              space_i,
  output kte_pkg::result_t             res_o
);

  logic [7:0] space_m1;

  assign space_m1 = space_i - 8'd1;

  always_comb begin
    res_o.bytes = '0;
    res_o.len   = kte_pkg::LenNone;
    priority if (cp_i == '0) begin
      res_o.len = kte_pkg::LenNone;
    end else if (cp_i <= 21'h7f) begin
      res_o.bytes[0] = cp_i[7:0];
      res_o.len      = kte_pkg::LenOne;
    end else if (cp_i <= 21'h7ff) begin
      res_o.bytes[0] = {3'b110, cp_i[10:6]};
      res_o.bytes[1] = {2'b10, cp_i[5:0]};
      res_o.len      = kte_pkg::LenTwo;
    end else if (cp_i >= kte_pkg::CpSurrLo && cp_i <= kte_pkg::CpSurrHi) begin
      res_o.len = kte_pkg::LenNone;
    end else if (cp_i <= 21'hffff) begin
      res_o.bytes[0] = {4'b1110, cp_i[15:12]};
      res_o.bytes[1] = {2'b10, cp_i[11:6]};
      res_o.bytes[2] = {2'b10, cp_i[5:0]};
      res_o.len      = kte_pkg::LenThree;
    end else if (cp_i <= kte_pkg::CpMax) begin
      res_o.bytes[0] = {5'b11110, cp_i[20:18]};
      res_o.bytes[1] = {2'b10, cp_i[17:12]};
      res_o.bytes[2] = {2'b10, cp_i[11:6]};
      res_o.bytes[3] = {2'b10, cp_i[5:0]};
      res_o.len      = kte_pkg::LenFour;
    end else begin
      res_o.len = kte_pkg::LenNone;
    end

    priority if (space_i == 8'd0) begin
      res_o.fit = kte_pkg::LenNone;
    end else if ({5'd0, res_o.len} < space_m1) begin
      res_o.fit = res_o.len;
    end else begin
      res_o.fit = space_m1[kte_pkg::LenW-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/keysym_to_utf8_encoder.sv */
// An input beat passes the input register and then the result register before its result is valid.
// Throughput: one beat per cycle unless the output stalls; mapping and UTF-8 packing sit between the two registers.
// in_stall_o is raised only while the result register holds an unaccepted beat
// and the input register is full.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none

`include "keysym_to_utf8_encoder_assert.svh"

module keysym_to_utf8_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] keysym_i,
  input  wire logic [7:0]  buffer_space_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       utf8_byte0_o,
  output logic [7:0]       utf8_byte1_o,
  output logic [7:0]       utf8_byte2_o,
  output logic [7:0]       utf8_byte3_o,
  output logic [2:0]       encoded_length_o,
  output logic [2:0]       bytes_fitting_o
);

  logic                     in_valid_q;
  logic [31:0]              keysym_q;
  logic [7:0]               space_q;
  logic                     out_valid_q;
  kte_pkg::result_t         res_d;
  kte_pkg::result_t         res_q;
  logic [kte_pkg::CpW-1:0]  cp;
  logic                     out_adv;
  logic                     in_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_adv     = !in_valid_q || out_adv;
  assign in_stall_o = !in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_valid_i) begin
      keysym_q <= keysym_i;
      space_q  <= buffer_space_i;
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  kte_map u_map (
    .keysym_i (keysym_q),
    .cp_o     (cp)
  );

  kte_encode u_encode (
    .cp_i    (cp),
    .space_i (space_q),
    .res_o   (res_d)
  );

  assign out_valid_o      = out_valid_q;
  assign utf8_byte0_o     = res_q.bytes[0];
  assign utf8_byte1_o     = res_q.bytes[1];
  assign utf8_byte2_o     = res_q.bytes[2];
  assign utf8_byte3_o     = res_q.bytes[3];
  assign encoded_length_o = res_q.len;
  assign bytes_fitting_o  = res_q.fit;

  `KTE_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i), "input stalled without a blocked result")
  `KTE_ASSERT(a_len_range, out_valid_o |-> (encoded_length_o <= kte_pkg::LenFour), "encoded length above four")
  `KTE_ASSERT(a_fit_le_len, out_valid_o |-> (bytes_fitting_o <= encoded_length_o), "fitting bytes exceed length")
  `KTE_ASSERT(a_empty_zero, (out_valid_o && encoded_length_o == kte_pkg::LenNone) |-> (utf8_byte0_o == 8'd0), "byte set on empty result")

endmodule

`default_nettype wire

/* verif/keysym_to_utf8_encoder_tb.sv */
`default_nettype none

module keysym_to_utf8_encoder_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned LongHold   = 90;

  class utf8_scoreboard;
    kte_pkg::result_t encodings_due[$];
    int unsigned failures;
    int unsigned shown;
    int unsigned keysyms_noted;
    int unsigned results_checked;
    int unsigned truncated;
    int unsigned len_hist[5];

    function logic [23:0] map_code_point(logic [31:0] ks);
      logic [23:0] cp;
      cp = '0;
      if ((ks >= 32'h20 && ks <= 32'h7e) || (ks >= 32'ha0 && ks <= 32'hff)) begin
        cp = ks[23:0];
      end else if (ks >= kte_pkg::KsUnicodeLo && ks <= kte_pkg::KsUnicodeHi) begin
        cp = ks[23:0];
      end else if (ks >= kte_pkg::KsKpDigitLo && ks <= kte_pkg::KsKpDigitHi) begin
        cp = 24'h30 + 24'(ks - kte_pkg::KsKpDigitLo);
      end else begin
        case (ks)
          kte_pkg::KsBackSpace:                   cp = 24'h08;
          kte_pkg::KsTab, kte_pkg::KsKpTab:       cp = 24'h09;
          kte_pkg::KsReturn, kte_pkg::KsKpEnter:  cp = 24'h0d;
          kte_pkg::KsEscape:                      cp = 24'h1b;
          kte_pkg::KsDelete, kte_pkg::KsKpDelete: cp = 24'h7f;
          kte_pkg::KsKpSpace:                     cp = 24'h20;
          kte_pkg::KsKpMultiply:                  cp = 24'h2a;
          kte_pkg::KsKpAdd:                       cp = 24'h2b;
          kte_pkg::KsKpSeparator:                 cp = 24'h2c;
          kte_pkg::KsKpSubtract:                  cp = 24'h2d;
          kte_pkg::KsKpDecimal:                   cp = 24'h2e;
          kte_pkg::KsKpDivide:                    cp = 24'h2f;
          default:                                cp = '0;
        endcase
      end
      return cp;
    endfunction

    function kte_pkg::result_t pack_utf8(logic [23:0] cp, logic [7:0] space);
      kte_pkg::result_t r;
      int      room;
      r = '0;
      if (cp == '0) begin
        r.len = kte_pkg::LenNone;
      end else if (cp <= 24'h7f) begin
        r.bytes[0] = cp[7:0];
        r.len = kte_pkg::LenOne;
      end else if (cp <= 24'h7ff) begin
        r.bytes[0] = {3'b110, cp[10:6]};
        r.bytes[1] = {2'b10, cp[5:0]};
        r.len = kte_pkg::LenTwo;
      end else if (cp >= 24'(kte_pkg::CpSurrLo) && cp <= 24'(kte_pkg::CpSurrHi)) begin
        r.len = kte_pkg::LenNone;
      end else if (cp <= 24'hffff) begin
        r.bytes[0] = {4'b1110, cp[15:12]};
        r.bytes[1] = {2'b10, cp[11:6]};
        r.bytes[2] = {2'b10, cp[5:0]};
        r.len = kte_pkg::LenThree;
      end else if (cp <= 24'(kte_pkg::CpMax)) begin
        r.bytes[0] = {5'b11110, cp[20:18]};
        r.bytes[1] = {2'b10, cp[17:12]};
        r.bytes[2] = {2'b10, cp[11:6]};
        r.bytes[3] = {2'b10, cp[5:0]};
        r.len = kte_pkg::LenFour;
      end
      // one byte of the buffer is kept for the terminator
      if (space == 8'd0) begin
        r.fit = '0;
      end else begin
        room = int'(space) - 1;
        r.fit = (int'(r.len) < room) ? r.len : 3'(room);
      end
      return r;
    endfunction

    function void note_keysym(logic [31:0] ks, logic [7:0] space);
      kte_pkg::result_t r;
      r = pack_utf8(map_code_point(ks), space);
      encodings_due.push_back(r);
      keysyms_noted++;
      len_hist[r.len]++;
      if (r.fit < r.len) truncated++;
    endfunction

    function void report(string what, logic [7:0] exp_v, logic [7:0] act_v);
      failures++;
      if (shown < 60) begin
        shown++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_encoding(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 logic [7:0] b3, logic [2:0] len, logic [2:0] fit);
      kte_pkg::result_t e;
      if (encodings_due.size() == 0) begin
        report("unexpected beat, length", 8'h00, {5'b0, len});
        return;
      end
      e = encodings_due.pop_front();
      results_checked++;
      if (b0 !== e.bytes[0]) report("utf8_byte0", e.bytes[0], b0);
      if (b1 !== e.bytes[1]) report("utf8_byte1", e.bytes[1], b1);
      if (b2 !== e.bytes[2]) report("utf8_byte2", e.bytes[2], b2);
      if (b3 !== e.bytes[3]) report("utf8_byte3", e.bytes[3], b3);
      if (len !== e.len) report("encoded_length", {5'b0, e.len}, {5'b0, len});
      if (fit !== e.fit) report("bytes_fitting", {5'b0, e.fit}, {5'b0, fit});
    endfunction

    function int unsigned outstanding();
      return encodings_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] keysym = '0;
  logic [7:0]  buffer_space = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  utf8_b0, utf8_b1, utf8_b2, utf8_b3;
  logic [2:0]  enc_len, fit_len;

  int unsigned cycles = 0;
  int unsigned tx_mode = 0;
  int unsigned rx_mode = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_seen = 1'b0;

  utf8_scoreboard sb = new();

  keysym_to_utf8_encoder dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .keysym_i         (keysym),
    .buffer_space_i   (buffer_space),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .utf8_byte0_o     (utf8_b0),
    .utf8_byte1_o     (utf8_b1),
    .utf8_byte2_o     (utf8_b2),
    .utf8_byte3_o     (utf8_b3),
    .encoded_length_o (enc_len),
    .bytes_fitting_o  (fit_len)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.outstanding());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // 0: no idling, 1: uniform 0..17, 2: mostly back to back
  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(17, 0);
      default: return ($urandom_range(3, 0) == 0) ? $urandom_range(17, 1) : 0;
    endcase
  endfunction

  function automatic logic [31:0] special_key(int unsigned idx);
    case (idx)
      0:       return kte_pkg::KsBackSpace;
      1:       return kte_pkg::KsTab;
      2:       return kte_pkg::KsKpTab;
      3:       return kte_pkg::KsReturn;
      4:       return kte_pkg::KsKpEnter;
      5:       return kte_pkg::KsEscape;
      6:       return kte_pkg::KsDelete;
      7:       return kte_pkg::KsKpDelete;
      8:       return kte_pkg::KsKpSpace;
      9:       return kte_pkg::KsKpMultiply;
      10:      return kte_pkg::KsKpAdd;
      11:      return kte_pkg::KsKpSeparator;
      12:      return kte_pkg::KsKpSubtract;
      13:      return kte_pkg::KsKpDecimal;
      default: return kte_pkg::KsKpDivide;
    endcase
  endfunction

  function automatic logic [31:0] unicode_edge(int unsigned idx);
    case (idx)
      0:       return kte_pkg::KsUnicodeLo - 32'd1;
      1:       return kte_pkg::KsUnicodeLo;
      2:       return kte_pkg::KsUnicodeHi;
      3:       return kte_pkg::KsUnicodeHi + 32'd1;
      4:       return 32'h0100_d7ff;
      5:       return 32'h0100_d800;
      6:       return 32'h0100_dfff;
      default: return 32'h0100_e000;
    endcase
  endfunction

  function automatic logic [31:0] pick_keysym();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 15) return $urandom_range(32'h7e, 32'h20);
    if (sel < 25) return $urandom_range(32'hff, 32'ha0);
    if (sel < 33) return $urandom_range(32'h1ff, 32'h0);
    if (sel < 48) return special_key($urandom_range(14, 0));
    if (sel < 56) return $urandom_range(32'hffff, 32'hff00);
    if (sel < 65) return 32'h0100_0000 + $urandom_range(32'h7ff, 32'h100);
    if (sel < 72) return 32'h0100_0000 + $urandom_range(32'hffff, 32'h800);
    if (sel < 75) return 32'h0100_0000 + $urandom_range(32'hdfff, 32'hd800);
    if (sel < 84) return 32'h0100_0000 + $urandom_range(32'h10ffff, 32'h10000);
    if (sel < 90) return unicode_edge($urandom_range(7, 0));
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_space();
    if ($urandom_range(9, 0) < 7) return 8'($urandom_range(6, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  // entered and left just after a falling edge
  task automatic send_beat(input logic [31:0] ks, input logic [7:0] space);
    int unsigned gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    keysym       <= ks;
    buffer_space <= space;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_keysym(ks, space);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin : receiver
    int unsigned gap;
    do @(negedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        gap = LongHold;
        long_hold_req = 1'b0;
        long_hold_seen = 1'b1;
      end else begin
        gap = draw_gap(rx_mode);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_encoding(utf8_b0, utf8_b1, utf8_b2, utf8_b3, enc_len, fit_len);
      @(negedge clk);
    end
  end

  initial begin : sender
    logic [31:0] edge_keys[$];
    int unsigned i;
    edge_keys = {32'h0000_0000, 32'hffff_ffff, 32'h0000_0020, 32'h0000_007e,
                 32'h0000_007f, 32'h0000_00a0, 32'h0000_00ff, 32'h0100_00ff,
                 32'h0100_0100, 32'h0100_07ff, 32'h0100_0800, 32'h0100_d7ff,
                 32'h0100_d800, 32'h0100_dfff, 32'h0100_ffff, 32'h0101_0000,
                 32'h0110_ffff, 32'h0111_0000, kte_pkg::KsKpDigitLo,
                 kte_pkg::KsKpDigitHi, kte_pkg::KsBackSpace, kte_pkg::KsDelete,
                 kte_pkg::KsKpDivide, 32'h8000_0000};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_mode = 2;
    rx_mode = 2;
    for (i = 0; i < edge_keys.size(); i++) begin
      send_beat(edge_keys[i], (i % 9 == 8) ? 8'hff : 8'(i % 9));
    end
    drain_results();

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin tx_mode = 0; rx_mode = 0; end
        1: begin tx_mode = 1; rx_mode = 1; end
        2: begin tx_mode = 0; rx_mode = 0; long_hold_req = 1'b1; end
        3: begin tx_mode = 2; rx_mode = 1; end
        4: begin tx_mode = 1; rx_mode = 2; end
        default: begin tx_mode = 2; rx_mode = 2; end
      endcase
      for (i = 0; i < PhaseItems; i++) begin
        send_beat(pick_keysym(), pick_space());
      end
      drain_results();
    end

    repeat (8) @(negedge clk);
    $display("%0d keysyms sent, %0d results checked, %0d cut short by the buffer",
             sb.keysyms_noted, sb.results_checked, sb.truncated);
    $display("lengths 0/1/2/3/4: %0d/%0d/%0d/%0d/%0d, long output hold-off %s",
             sb.len_hist[0], sb.len_hist[1], sb.len_hist[2], sb.len_hist[3],
             sb.len_hist[4], long_hold_seen ? "done" : "missed");
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
